FILE: rtl/ptt_pkg.sv
// Shared types and constants for the priority task table.
// Used by the front end, command queue, back end, top level and checker.
`default_nettype none

package ptt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W   = 2;
    localparam int USER_W = 16;
    localparam int TASK_W = 16;
    localparam int PRIO_W = 32;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_EDIT   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EXEC   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_DRAIN = 2'd2,
        S_WRITE = 2'd3
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [USER_W-1:0]  user_id;
        logic [TASK_W-1:0]  task_id;
        logic [PRIO_W-1:0]  prio;
    } t_cmd;

    // Queue status seen by the back end
    typedef struct packed {
        logic empty;
        t_cmd cmd;
    } t_q_head;

endpackage

`default_nettype wire

FILE: rtl/ptt_front.sv
// Front end: decodes an incoming item into a command and masks unused fields.
// Depends on ptt_pkg.
`default_nettype none

module ptt_front
    import ptt_pkg::*;
(
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [USER_W-1:0] i_user_id,
    input  wire logic [TASK_W-1:0] i_task_id,
    input  wire logic [PRIO_W-1:0] i_priority_req,
    output t_cmd                   o_cmd
);

    t_op op;

    always_comb begin
        op            = t_op'(i_op);
        o_cmd.op      = op;
        o_cmd.user_id = '0;
        o_cmd.task_id = i_task_id;
        o_cmd.prio    = '0;
        unique case (op)
            OP_ADD: begin
                o_cmd.user_id = i_user_id;
                o_cmd.prio    = i_priority_req;
            end
            OP_EDIT: begin
                o_cmd.prio = i_priority_req;
            end
            OP_REMOVE: begin
            end
            OP_EXEC: begin
                // top search needs no id
                o_cmd.task_id = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ptt_cmd_q.sv
// Short command queue between front end and back end.
// Depends on ptt_pkg.
`default_nettype none

module ptt_cmd_q
    import ptt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output t_q_head   o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push_ok;
    logic              pop_ok;

    assign push_ok     = i_push && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign pop_ok      = i_pop && (r_count != '0);
    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.empty = (r_count == '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ptt_back.sv
// Back end: holds the task table and carries out one command at a time by
// scanning every entry, then updating the table and issuing the result.
// Depends on ptt_pkg.
`default_nettype none

module ptt_back
    import ptt_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_q_head       i_head,
    output logic               o_pop,
    output logic               o_strobe,
    output logic [STAT_W-1:0]  o_status,
    output logic [USER_W-1:0]  o_served_user
);

    // table storage; valid bits live in flops
    logic [TASK_W-1:0] mem_task [TABLE_DEPTH];
    logic [USER_W-1:0] mem_user [TABLE_DEPTH];
    logic [PRIO_W-1:0] mem_prio [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    t_state r_state, n_state;
    t_cmd   r_cmd;

    logic [IDX_W-1:0]  r_addr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [TASK_W-1:0] r_rd_task;
    logic [USER_W-1:0] r_rd_user;
    logic [PRIO_W-1:0] r_rd_prio;

    logic              r_match_hit;
    logic [IDX_W-1:0]  r_match_idx;
    logic              r_free_hit;
    logic [IDX_W-1:0]  r_free_idx;
    logic              r_best_hit;
    logic [IDX_W-1:0]  r_best_idx;
    logic [TASK_W-1:0] r_best_task;
    logic [PRIO_W-1:0] r_best_prio;
    logic [USER_W-1:0] r_best_user;

    logic              r_out_stb;
    t_status           r_out_status;
    logic [USER_W-1:0] r_out_served;

    logic              ent_valid;
    logic              wr_all;
    logic              wr_prio;
    logic              set_v;
    logic              clr_v;
    logic [IDX_W-1:0]  slot;
    logic              done;
    t_status           status;
    logic [USER_W-1:0] served;

    assign ent_valid = r_valid[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        wr_all  = 1'b0;
        wr_prio = 1'b0;
        set_v   = 1'b0;
        clr_v   = 1'b0;
        slot    = r_match_idx;
        done    = 1'b0;
        status  = ST_OK;
        served  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_head.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                done    = 1'b1;
                n_state = S_IDLE;
                unique case (r_cmd.op)
                    OP_ADD: begin
                        // overwrite a present id, else take the lowest free slot
                        if (r_match_hit) begin
                            wr_all = 1'b1;
                            set_v  = 1'b1;
                        end else if (r_free_hit) begin
                            slot   = r_free_idx;
                            wr_all = 1'b1;
                            set_v  = 1'b1;
                        end else begin
                            status = ST_FULL;
                        end
                    end
                    OP_EDIT: begin
                        if (r_match_hit) begin
                            wr_prio = 1'b1;
                        end else begin
                            status = ST_MISSING;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_match_hit) begin
                            clr_v = 1'b1;
                        end else begin
                            status = ST_MISSING;
                        end
                    end
                    OP_EXEC: begin
                        if (r_best_hit) begin
                            slot   = r_best_idx;
                            clr_v  = 1'b1;
                            served = r_best_user;
                        end else begin
                            status = ST_EMPTY;
                        end
                    end
                endcase
            end
        endcase
    end

    // table memory: one write port, one scan read port
    always_ff @(posedge i_clk) begin
        if (wr_all) begin
            mem_task[slot] <= r_cmd.task_id;
            mem_user[slot] <= r_cmd.user_id;
        end
        if (wr_all || wr_prio) begin
            mem_prio[slot] <= r_cmd.prio;
        end
        if (r_state == S_SCAN) begin
            r_rd_task <= mem_task[r_addr];
            r_rd_user <= mem_user[r_addr];
            r_rd_prio <= mem_prio[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_rd_vld     <= 1'b0;
            r_out_stb    <= 1'b0;
            r_out_status <= ST_OK;
            r_out_served <= '0;
        end else begin
            r_rd_vld  <= (r_state == S_SCAN);
            r_out_stb <= done;
            if (done) begin
                r_out_status <= status;
                r_out_served <= served;
            end
            if (set_v) begin
                r_valid[slot] <= 1'b1;
            end else if (clr_v) begin
                r_valid[slot] <= 1'b0;
            end
        end
    end

    // scan bookkeeping: match, lowest free slot, running maximum
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd       <= i_head.cmd;
            r_addr      <= '0;
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_best_hit  <= 1'b0;
        end else begin
            if (r_state == S_SCAN) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_rd_vld) begin
                if (ent_valid && (r_rd_task == r_cmd.task_id)) begin
                    r_match_hit <= 1'b1;
                    r_match_idx <= r_rd_idx;
                end
                if (!ent_valid && !r_free_hit) begin
                    r_free_hit <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
                if (ent_valid && (!r_best_hit ||
                        ({r_rd_prio, r_rd_task} > {r_best_prio, r_best_task}))) begin
                    r_best_hit  <= 1'b1;
                    r_best_idx  <= r_rd_idx;
                    r_best_task <= r_rd_task;
                    r_best_prio <= r_rd_prio;
                    r_best_user <= r_rd_user;
                end
            end
        end
    end

    assign o_strobe      = r_out_stb;
    assign o_status      = r_out_status;
    assign o_served_user = r_out_served;

endmodule

`default_nettype wire

FILE: rtl/priority_task_table.sv
// Priority task table: each item scans all TABLE_DEPTH entries through the
// single table read port, one entry per cycle. A two-entry queue lets busy stay
// low while an item is in work. Synchronous reset clears the table and queue.
// Depends on ptt_pkg, ptt_front, ptt_cmd_q and ptt_back.
`default_nettype none

module priority_task_table
    import ptt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [USER_W-1:0] i_user_id,
    input  wire logic [TASK_W-1:0] i_task_id,
    input  wire logic [PRIO_W-1:0] i_priority_req,
    output logic                   o_strobe,
    output logic [STAT_W-1:0]      o_status,
    output logic [USER_W-1:0]      o_served_user
);

    t_cmd    front_cmd;
    t_q_head q_head;
    logic    q_full;
    logic    q_pop;

    ptt_front u_front (
        .i_op           (i_op),
        .i_user_id      (i_user_id),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .o_cmd          (front_cmd)
    );

    ptt_cmd_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start && !q_full),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    ptt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_served_user (o_served_user)
    );

    assign busy = q_full;

endmodule

`default_nettype wire

FILE: rtl/ptt_checker.sv
// Port-level checker for the priority task table, bound to the top level.
// Depends on ptt_pkg.
`default_nettype none

module ptt_checker
    import ptt_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              busy,
    input wire logic              o_strobe,
    input wire logic [STAT_W-1:0] o_status,
    input wire logic [USER_W-1:0] o_served_user
);

    // outputs and busy come up quiet after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("strobe or busy set right after reset");

    // a full table scan lies between two results
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results on consecutive cycles");

    // only a served task carries a user
    a_served_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> (o_served_user == '0))
        else $error("served user set on a failed item");

    // a queue slot frees only when the back end finishes an item
    a_busy_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> $past(o_strobe))
        else $error("busy dropped without a finished item");

endmodule

bind priority_task_table ptt_checker u_chk (.*);

`default_nettype wire

FILE: sim/tb.sv
// Testbench for priority_task_table: add, edit, remove and execute-top items.
// Expected status and served user come from a table model kept in the bench.
// Depends on ptt_pkg and the RTL of priority_task_table.
`timescale 1ns / 100ps

module tb;
    import ptt_pkg::*;

    localparam int NO_SLOT = -1;

    typedef struct {
        t_status           status;
        logic [USER_W-1:0] user;
    } t_outcome;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_op           = '0;
    logic [USER_W-1:0] i_user_id      = '0;
    logic [TASK_W-1:0] i_task_id      = '0;
    logic [PRIO_W-1:0] i_priority_req = '0;
    logic              o_strobe;
    logic [STAT_W-1:0] o_status;
    logic [USER_W-1:0] o_served_user;

    // Bench copy of the task table, empty after reset
    logic              tbl_valid [TABLE_DEPTH] = '{default: 1'b0};
    logic [TASK_W-1:0] tbl_task  [TABLE_DEPTH];
    logic [USER_W-1:0] tbl_user  [TABLE_DEPTH];
    logic [PRIO_W-1:0] tbl_prio  [TABLE_DEPTH];

    t_outcome pending_outcomes[$];
    int       mismatches = 0;
    bit       no_gaps    = 1'b0;

    priority_task_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_user_id      (i_user_id),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_served_user  (o_served_user)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int slot_of(input logic [TASK_W-1:0] tid);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i] && tbl_task[i] == tid) return i;
        return NO_SLOT;
    endfunction

    function automatic int occupancy();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) n += tbl_valid[i];
        return n;
    endfunction

    // Apply one command to the bench table and return what the block must report
    function automatic t_outcome apply_cmd(input t_op op, input logic [USER_W-1:0] user,
                                           input logic [TASK_W-1:0] tid,
                                           input logic [PRIO_W-1:0] prio);
        t_outcome res;
        int       s;
        res.status = ST_OK;
        res.user   = '0;
        s          = NO_SLOT;
        case (op)
            OP_ADD: begin
                s = slot_of(tid);
                if (s == NO_SLOT) begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                        if (!tbl_valid[i]) s = i;
                end
                if (s == NO_SLOT) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_valid[s] = 1'b1;
                    tbl_task[s]  = tid;
                    tbl_user[s]  = user;
                    tbl_prio[s]  = prio;
                end
            end
            OP_EDIT: begin
                s = slot_of(tid);
                if (s == NO_SLOT) res.status = ST_MISSING;
                else tbl_prio[s] = prio;
            end
            OP_REMOVE: begin
                s = slot_of(tid);
                if (s == NO_SLOT) res.status = ST_MISSING;
                else tbl_valid[s] = 1'b0;
            end
            default: begin
                // highest priority wins, ties go to the larger task id
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_valid[i] && (s == NO_SLOT || tbl_prio[i] > tbl_prio[s] ||
                        (tbl_prio[i] == tbl_prio[s] && tbl_task[i] > tbl_task[s])))
                        s = i;
                end
                if (s == NO_SLOT) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.user     = tbl_user[s];
                    tbl_valid[s] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Caller is always just past a rising edge
    task automatic send_item(input t_op op, input logic [USER_W-1:0] user,
                             input logic [TASK_W-1:0] tid, input logic [PRIO_W-1:0] prio);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= op;
        i_user_id      <= user;
        i_task_id      <= tid;
        i_priority_req <= prio;
        do @(posedge i_clk); while (busy);
        pending_outcomes.push_back(apply_cmd(op, user, tid, prio));
    endtask

    // Hold off until every item in flight has reported
    task automatic wait_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [PRIO_W-1:0] rand_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(0, 3);
        if (r < 35) return '0;
        if (r < 40) return '1;
        return $urandom;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            if (pending_outcomes.size() == 0) begin
                note_mismatch("result with no item waiting, status", 0, o_status);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", want.status, o_status);
                if (o_served_user !== want.user)
                    note_mismatch("served_user", want.user, o_served_user);
            end
        end
    end

    task automatic test_directed();
        send_item(OP_EXEC, 16'h0, 16'h0, 32'h0);
        send_item(OP_EDIT, 16'h1, 16'h5, 32'h9);
        send_item(OP_REMOVE, 16'h1, 16'h5, 32'h0);
        send_item(OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_ADD, 16'h0, 16'h0, 32'h0);
        send_item(OP_ADD, 16'd1234, 16'd7, 32'd100);
        send_item(OP_ADD, 16'd4321, 16'd7, 32'd50);
        send_item(OP_ADD, 16'd77, 16'd9, 32'd50);
        send_item(OP_EDIT, 16'hFFFF, 16'd0, 32'd50);
        send_item(OP_EXEC, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_EXEC, 16'h0, 16'h0, 32'h0);
        send_item(OP_EXEC, 16'h0, 16'h0, 32'h0);
        send_item(OP_EXEC, 16'h0, 16'h0, 32'h0);
        send_item(OP_EXEC, 16'h0, 16'h0, 32'h0);
        send_item(OP_ADD, 16'd55, 16'd3, 32'd10);
        send_item(OP_REMOVE, 16'hFFFF, 16'd3, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 16'h0, 16'd3, 32'h0);
        send_item(OP_EDIT, 16'h0, 16'hFFFF, 32'h1);
        send_item(OP_ADD, 16'hA5A5, 16'h5A5A, 32'h8000_0000);
        send_item(OP_EDIT, 16'h1, 16'h5A5A, 32'h7FFF_FFFF);
        send_item(OP_EXEC, 16'h0, 16'h0, 32'h0);
        send_item(OP_EXEC, 16'h0, 16'h0, 32'h0);
    endtask

    task automatic test_full_table();
        logic [TASK_W-1:0] tid;
        while (occupancy() < TABLE_DEPTH) begin
            tid = $urandom;
            if (slot_of(tid) == NO_SLOT)
                send_item(OP_ADD, $urandom, tid, $urandom_range(0, 7));
        end
        repeat (3) begin
            tid = $urandom;
            if (slot_of(tid) == NO_SLOT) send_item(OP_ADD, $urandom, tid, rand_prio());
        end
        // overwrite and edit still work on a full table
        send_item(OP_ADD, $urandom, tbl_task[$urandom_range(0, TABLE_DEPTH - 1)], rand_prio());
        send_item(OP_EDIT, $urandom, tbl_task[$urandom_range(0, TABLE_DEPTH - 1)], rand_prio());
        send_item(OP_REMOVE, $urandom, tbl_task[$urandom_range(0, TABLE_DEPTH - 1)], $urandom);
        do tid = $urandom; while (slot_of(tid) != NO_SLOT);
        send_item(OP_ADD, $urandom, tid, rand_prio());
        repeat (TABLE_DEPTH + 1) send_item(OP_EXEC, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random(input int count);
        logic [TASK_W-1:0] id_pool [16];
        logic [TASK_W-1:0] tid;
        int                r;
        t_op               op;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                wait_results();
                foreach (id_pool[k]) id_pool[k] = $urandom;
            end
            if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r   = $urandom_range(0, 99);
            op  = r < 40 ? OP_ADD : r < 60 ? OP_EDIT : r < 75 ? OP_REMOVE : OP_EXEC;
            tid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 15)];
            send_item(op, $urandom, tid, rand_prio());
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_results();
        test_full_table();
        wait_results();
        test_random(500);
        wait_results();
        repeat (TABLE_DEPTH + 20) @(posedge i_clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
rtl/ptt_pkg.sv
rtl/ptt_front.sv
rtl/ptt_cmd_q.sv
rtl/ptt_back.sv
rtl/priority_task_table.sv
rtl/ptt_checker.sv
sim/tb.sv
